[rtl/trcc_pkg.sv]
// Shared types, constants and helper functions for the two-rotor character cipher.
// Imported by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package trcc_pkg;

  // Rotor geometry.
  localparam int unsigned RotorSize = 28;
  localparam int unsigned IdxW      = $clog2(RotorSize);

  typedef logic [IdxW-1:0] idx_t;

  localparam logic [IdxW:0] RotorSizeW = (IdxW + 1)'(RotorSize);
  localparam idx_t          IdxLast    = idx_t'(RotorSize - 1);
  localparam idx_t          IdxSpace   = idx_t'(26);
  localparam idx_t          IdxDot     = idx_t'(27);

  // Character codes.
  localparam logic [7:0] CharUpperA = 8'd65;
  localparam logic [7:0] CharUpperZ = 8'd90;
  localparam logic [7:0] CharLowerA = 8'd97;
  localparam logic [7:0] CharLowerZ = 8'd122;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharDot    = 8'd46;
  localparam logic [7:0] CaseOffset = 8'd32;

  // Payload and configuration widths.
  localparam int unsigned CharW     = 8;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;

  // Item kinds carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_START       = 2'd2,
    MODE_CHAR        = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_START  = 2'd0,
    CFG_SECOND_START = 2'd1,
    CFG_DECRYPT      = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic char_take;
    logic look;
    logic scan;
    logic drain;
    logic wb;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic char_ok;
    logic scan_last;
  } status_t;

  // Sum of two rotor positions, reduced modulo the rotor size.
  function automatic idx_t trcc_mod_add(idx_t a, idx_t b);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= RotorSizeW) begin
      s = s - RotorSizeW;
    end
    return s[IdxW-1:0];
  endfunction

  // Reduce a five-bit offset below the rotor size.
  function automatic idx_t trcc_reduce(idx_t a);
    idx_t r;
    r = a;
    if ({1'b0, a} >= RotorSizeW) begin
      r = a - RotorSizeW[IdxW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/trcc_if.sv]
// Handshake channel interfaces: character items in, result items out, configuration writes.
// Depends on trcc_pkg for the payload widths.
`timescale 1ns / 1ps

interface trcc_in_if
  import trcc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [IdxW-1:0]     entry_index;
  logic [CharW-1:0]    entry_value;
  logic [CharW-1:0]    char_in;

  modport source (output valid, output mode, output entry_index, output entry_value,
                  output char_in, input ready);
  modport sink   (input valid, input mode, input entry_index, input entry_value,
                  input char_in, output ready);
endinterface

interface trcc_out_if
  import trcc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_out;
  logic             was_ciphered;

  modport source (output valid, output char_out, output was_ciphered, input ready);
  modport sink   (input valid, input char_out, input was_ciphered, output ready);
endinterface

interface trcc_cfg_if
  import trcc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/trcc_ctrl.sv]
// Controller state machine for the two-rotor cipher: sequences load, start and character items.
// Depends on trcc_pkg for the state, mode, command and status types.
`timescale 1ns / 1ps

module trcc_ctrl
  import trcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ModeW-1:0] in_mode_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  status_t          status_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_e'(in_mode_i))
            MODE_LOAD_FIRST:  cmd_o.load_first  = 1'b1;
            MODE_LOAD_SECOND: cmd_o.load_second = 1'b1;
            MODE_START:       cmd_o.start       = 1'b1;
            MODE_CHAR: begin
              cmd_o.char_take = 1'b1;
              state_d = status_i.char_ok ? ST_LOOK : ST_WB;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.drain = 1'b1;
        state_d     = ST_WB;
      end
      ST_WB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.wb = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The output register fills on write-back and empties when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.wb) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

[rtl/trcc_dpath.sv]
// Datapath for the two-rotor cipher: rotor memories, positions, configuration and the scan.
// Depends on trcc_pkg for constants, types and the modular add helpers.
`timescale 1ns / 1ps

module trcc_dpath
  import trcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic [CharW-1:0]    entry_value_i,
  input  logic [CharW-1:0]    char_in_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [CharW-1:0]    char_out_o,
  output logic                was_ciphered_o
);

  // Rotor tables, kept unrotated.
  logic [CharW-1:0] tab1_mem [RotorSize];
  logic [CharW-1:0] tab2_mem [RotorSize];
  logic [CharW-1:0] rd1_q, rd2_q;

  // Configuration and rotor position registers.
  idx_t first_start_q, second_start_q;
  logic decrypt_q;
  idx_t pos1_q, pos2_q;

  // Scan control.
  logic [IdxW:0] cnt_q;
  logic          cmp_v_q;
  idx_t          cmp_i_q;

  // Per-character payload.
  idx_t             idx_q, found_q;
  logic             pass_q;
  logic [CharW-1:0] byte_q, look_q;
  logic [CharW-1:0] char_out_q;
  logic             was_ciphered_q;

  logic [CharW-1:0] up_char;
  logic             is_letter;
  logic             char_ok;
  idx_t             char_idx;
  idx_t             pos_j, neg_pos1, addr1, addr2;
  logic             entry_ok;
  logic [CharW-1:0] look_data, scan_data;
  logic [CharW-1:0] cipher_char;

  // Upper-case the byte and classify it.
  always_comb begin
    up_char = char_in_i;
    if (char_in_i >= CharLowerA && char_in_i <= CharLowerZ) begin
      up_char = char_in_i - CaseOffset;
    end
    is_letter = (up_char >= CharUpperA) && (up_char <= CharUpperZ);
    char_ok   = is_letter || (up_char == CharSpace) || (up_char == CharDot);
    if (is_letter) begin
      char_idx = idx_t'(up_char - CharUpperA);
    end else if (up_char == CharSpace) begin
      char_idx = IdxSpace;
    end else begin
      char_idx = IdxDot;
    end
  end

  assign status_o.char_ok   = char_ok;
  assign status_o.scan_last = (cnt_q == {1'b0, IdxLast});

  // Rotated read addresses: the first rotor turns right, the second left.
  assign pos_j    = cmd_i.look ? idx_q : cnt_q[IdxW-1:0];
  assign neg_pos1 = (pos1_q == '0) ? '0 : idx_t'(RotorSizeW - {1'b0, pos1_q});
  assign addr1    = trcc_mod_add(pos_j, neg_pos1);
  assign addr2    = trcc_mod_add(pos_j, pos2_q);
  assign entry_ok = ({1'b0, entry_index_i} < RotorSizeW);

  // Rotor memories: one write and one registered read per table.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_first && entry_ok) begin
      tab1_mem[entry_index_i] <= entry_value_i;
    end
    if (cmd_i.load_second && entry_ok) begin
      tab2_mem[entry_index_i] <= entry_value_i;
    end
    rd1_q <= tab1_mem[addr1];
    rd2_q <= tab2_mem[addr2];
  end

  // In decrypt direction the tables swap roles.
  assign look_data = decrypt_q ? rd2_q : rd1_q;
  assign scan_data = decrypt_q ? rd1_q : rd2_q;

  // Configuration, positions and scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_start_q  <= '0;
      second_start_q <= '0;
      decrypt_q      <= 1'b0;
      pos1_q         <= '0;
      pos2_q         <= '0;
      cnt_q          <= '0;
      cmp_v_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_FIRST_START:  first_start_q  <= cfg_data_i[IdxW-1:0];
          CFG_SECOND_START: second_start_q <= cfg_data_i[IdxW-1:0];
          CFG_DECRYPT:      decrypt_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        pos1_q <= trcc_reduce(first_start_q);
        pos2_q <= trcc_reduce(second_start_q);
      end else if (cmd_i.wb && !pass_q) begin
        pos1_q <= trcc_mod_add(pos1_q, idx_t'(1));
        pos2_q <= trcc_mod_add(pos2_q, idx_t'(1));
      end
      if (cmd_i.char_take) begin
        cnt_q   <= '0;
        cmp_v_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cnt_q   <= cnt_q + 1'b1;
        cmp_v_q <= 1'b1;
      end else if (cmd_i.drain) begin
        cmp_v_q <= 1'b0;
      end
    end
  end

  // Map the found index back to a character.
  always_comb begin
    if (found_q == IdxSpace) begin
      cipher_char = CharSpace;
    end else if (found_q == IdxDot) begin
      cipher_char = CharDot;
    end else begin
      cipher_char = CharUpperA + CharW'(found_q);
    end
  end

  // Character payload, look-up value, last match and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.char_take) begin
      idx_q   <= char_idx;
      found_q <= char_idx;
      pass_q  <= !char_ok;
      byte_q  <= up_char;
    end else if (cmp_v_q && (scan_data == look_q)) begin
      found_q <= cmp_i_q;
    end
    if (cmd_i.scan) begin
      cmp_i_q <= cnt_q[IdxW-1:0];
      if (cnt_q == '0) begin
        look_q <= look_data;
      end
    end
    if (cmd_i.wb) begin
      char_out_q     <= pass_q ? byte_q : cipher_char;
      was_ciphered_q <= !pass_q;
    end
  end

  assign char_out_o     = char_out_q;
  assign was_ciphered_o = was_ciphered_q;

endmodule

[rtl/two_rotor_char_cipher_core.sv]
// Top level of the two-rotor character cipher: joins the controller and the datapath.
// Depends on trcc_pkg, the channel interfaces, trcc_ctrl and trcc_dpath.
//
// Use: rotor tables are filled with load items (mode 0 and 1), one entry per item.
// A start item (mode 2) sets both rotor positions from the configured offsets.
// Character items (mode 3) give one result item each; loads and starts give none.
// The configuration channel is always ready and should be written only while idle.
// Load and start items leave the block idle, so the next item is accepted on the
// following cycle. A pass-through byte goes from acceptance straight to write-back.
// A ciphered character passes through the acceptance, one look-up read, a 28-step scan
// of the other rotor table through its single read port, a drain of the read register
// and one write-back; that scan is the longest of these steps.
// The result sits in an output register, so the next item may be accepted while
// it waits; a stalled receiver holds the block only at write-back of a new result.
// Reset clears the positions, the offsets and the direction; table contents are
// undefined until written.
`timescale 1ns / 1ps

module two_rotor_char_cipher_core
  import trcc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  trcc_cfg_if.sink     cfg_i,
  trcc_in_if.sink      in_i,
  trcc_out_if.source   out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  // Sequencing.
  trcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tables, positions and result.
  trcc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .entry_index_i  (in_i.entry_index),
    .entry_value_i  (in_i.entry_value),
    .char_in_i      (in_i.char_in),
    .cmd_i          (cmd),
    .status_o       (status),
    .char_out_o     (out_o.char_out),
    .was_ciphered_o (out_o.was_ciphered)
  );

endmodule

[rtl/trcc_checker.sv]
// Port-level checks for the two-rotor cipher, attached to the top level by a bind.
// Depends on trcc_pkg for the mode and character codes.
`timescale 1ns / 1ps

module trcc_checker
  import trcc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [ModeW-1:0] in_mode_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] char_out_i,
  input logic             was_ciphered_i
);

  logic in_acc;
  logic out_cipher_set;
  logic out_lower;

  assign in_acc         = in_valid_i && in_ready_i;
  assign out_cipher_set = (char_out_i >= CharUpperA && char_out_i <= CharUpperZ) ||
                          (char_out_i == CharSpace) || (char_out_i == CharDot);
  assign out_lower      = (char_out_i >= CharLowerA) && (char_out_i <= CharLowerZ);

  // A waiting result is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item withdrawn before it was taken");

  // Work on a character holds off the next item in the cycle after its acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_mode_i == MODE_CHAR) |=> !in_ready_i)
    else $error("item accepted while a character was in progress");

  // A new result never appears the cycle after an item was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc))
    else $error("result appeared too early after acceptance");

  // A ciphered result is a letter, a space or a dot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && was_ciphered_i |-> out_cipher_set)
    else $error("ciphered result outside the rotor alphabet");

  // A passed-through byte is never a letter, space, dot or lower-case letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !was_ciphered_i |-> !out_cipher_set && !out_lower)
    else $error("cipherable byte passed through unchanged");

endmodule

bind two_rotor_char_cipher_core trcc_checker u_trcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_mode_i      (in_i.mode),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .char_out_i     (out_o.char_out),
  .was_ciphered_i (out_o.was_ciphered)
);
